FILE: src/phc_pkg.sv
package phc_pkg;

  localparam int unsigned OffsetW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutCountW = $clog2(OutDepth + 1);

  localparam logic [OffsetW-1:0] OffsetMax = 7'd127;
  localparam logic [OffsetW-1:0] MacFirst = 7'd6;
  localparam logic [OffsetW-1:0] MacLast = 7'd9;
  localparam logic [OffsetW-1:0] EtherTypeHi = 7'd12;
  localparam logic [OffsetW-1:0] EtherTypeLo = 7'd13;
  localparam logic [OffsetW-1:0] VersionPos = 7'd14;
  localparam logic [OffsetW-1:0] ProtocolPos = 7'd23;
  localparam logic [OffsetW-1:0] EthHdrLen = 7'd14;
  localparam logic [OffsetW-1:0] EthLastPos = 7'd13;
  localparam logic [OffsetW-1:0] IpLastPos = 7'd33;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [3:0] IpVersion4 = 4'd4;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [CfgIdxW-1:0] CfgMacSignature = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTcpDestPort = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSocketBound = 2'd2;

  localparam logic [15:0] MacSignatureReset = 16'h3607;
  localparam logic [15:0] TcpDestPortReset = 16'd443;

  typedef struct packed {
    logic [31:0] mac_head;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [7:0]  protocol;
    logic [15:0] l4_dst_port;
  } hdr_t;

  typedef struct packed {
    logic               valid;
    logic [OffsetW-1:0] pos;
  } req_t;

  typedef struct packed {
    logic valid;
    logic tcp_hit;
    logic udp_hit;
    logic redirect;
  } dec_t;

  typedef struct packed {
    logic [15:0] mac_signature;
    logic [15:0] tcp_port;
    logic        socket_bound;
  } cfg_t;

  function automatic logic [OffsetW-1:0] transport_offset(input logic [7:0] version_ihl);
    return EthHdrLen + {1'b0, version_ihl[3:0], 2'b00};
  endfunction

endpackage

FILE: src/phc_byte_if.sv
interface phc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

FILE: src/phc_cfg_if.sv
interface phc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [phc_pkg::CfgIdxW-1:0]    index;
  logic [phc_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/phc_result_if.sv
interface phc_result_if #(
  parameter int unsigned CountBits = 64
);
  logic                 valid;
  logic                 ready;
  logic                 verdict;
  logic [CountBits-1:0] total_count;
  logic [CountBits-1:0] tcp_count;
  logic [CountBits-1:0] udp_count;
  logic [CountBits-1:0] redirect_count;

  modport source (output valid, output verdict, output total_count, output tcp_count,
                  output udp_count, output redirect_count, input ready);
  modport sink (input valid, input verdict, input total_count, input tcp_count,
                input udp_count, input redirect_count, output ready);
endinterface

FILE: src/packet_header_classifier.sv
// Ethernet/IPv4 header classifier. Frame bytes enter one per cycle in wire order, and a new
// byte can be taken in every cycle unless the input is held off. Each final byte yields one
// result item with the verdict and the four wrapping frame counters; its valid rises once
// the item has passed the parser's request register, the decision register and the output
// buffer. Results queue in a four-entry output buffer, and the byte input is held off only
// while four results are outstanding between the final-byte capture and the output.
// Configuration writes are always accepted and should be made while no frame is in flight.
module packet_header_classifier #(
  parameter int unsigned CounterBits = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  phc_byte_if.sink         frame_i,
  phc_cfg_if.sink          cfg_i,
  phc_result_if.source     result_o
);

  localparam int unsigned EntryW = 1 + 4 * CounterBits;

  phc_pkg::cfg_t cfg_q, cfg_d;
  phc_pkg::hdr_t hdr;
  phc_pkg::req_t req;
  phc_pkg::dec_t dec;

  logic                            accept;
  logic                            pop;
  logic [phc_pkg::OutCountW:0]     inflight;
  logic [phc_pkg::OutCountW-1:0]   fifo_count;
  logic [CounterBits-1:0]          total_d, tcp_d, udp_d, redirect_d;
  logic [EntryW-1:0]               push_data, head_data;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        phc_pkg::CfgMacSignature: cfg_d.mac_signature = cfg_i.data;
        phc_pkg::CfgTcpDestPort: cfg_d.tcp_port = cfg_i.data;
        phc_pkg::CfgSocketBound: cfg_d.socket_bound = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mac_signature <= phc_pkg::MacSignatureReset;
      cfg_q.tcp_port <= phc_pkg::TcpDestPortReset;
      cfg_q.socket_bound <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign inflight = (phc_pkg::OutCountW + 1)'(req.valid) + (phc_pkg::OutCountW + 1)'(dec.valid) +
                    (phc_pkg::OutCountW + 1)'(fifo_count);
  assign frame_i.ready = inflight < (phc_pkg::OutCountW + 1)'(phc_pkg::OutDepth);
  assign accept = frame_i.valid && frame_i.ready;

  phc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_byte_i (frame_i.frame_byte),
    .last_byte_i  (frame_i.last_byte),
    .hdr_o        (hdr),
    .req_o        (req)
  );

  phc_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .hdr_i  (hdr),
    .cfg_i  (cfg_q),
    .dec_o  (dec)
  );

  phc_stats #(
    .CountBits (CounterBits)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dec_i        (dec),
    .total_d_o    (total_d),
    .tcp_d_o      (tcp_d),
    .udp_d_o      (udp_d),
    .redirect_d_o (redirect_d)
  );

  assign push_data = {dec.redirect, total_d, tcp_d, udp_d, redirect_d};
  assign pop = result_o.valid && result_o.ready;

  phc_out_fifo #(
    .Width (EntryW),
    .Depth (phc_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (dec.valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .data_o      (head_data),
    .count_o     (fifo_count)
  );

  assign result_o.valid = fifo_count != '0;
  assign {result_o.verdict, result_o.total_count, result_o.tcp_count, result_o.udp_count,
          result_o.redirect_count} = head_data;

endmodule

FILE: src/phc_parser.sv
module phc_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [7:0]                      frame_byte_i,
  input  logic                            last_byte_i,
  output phc_pkg::hdr_t                   hdr_o,
  output phc_pkg::req_t                   req_o
);

  logic [phc_pkg::OffsetW-1:0] offset_q, offset_d;
  phc_pkg::hdr_t               hdr_q, hdr_d;
  phc_pkg::req_t               req_q, req_d;
  logic [phc_pkg::OffsetW-1:0] tp;

  assign tp = phc_pkg::transport_offset(hdr_q.version_ihl);

  always_comb begin
    offset_d = offset_q;
    hdr_d = hdr_q;
    req_d.valid = accept_i && last_byte_i;
    req_d.pos = offset_q;
    if (accept_i) begin
      if (last_byte_i) begin
        offset_d = '0;
      end else if (offset_q != phc_pkg::OffsetMax) begin
        offset_d = offset_q + 7'd1;
      end
      if (offset_q >= phc_pkg::MacFirst && offset_q <= phc_pkg::MacLast) begin
        hdr_d.mac_head = {hdr_q.mac_head[23:0], frame_byte_i};
      end else if (offset_q == phc_pkg::EtherTypeHi || offset_q == phc_pkg::EtherTypeLo) begin
        hdr_d.ether_type = {hdr_q.ether_type[7:0], frame_byte_i};
      end else if (offset_q == phc_pkg::VersionPos) begin
        hdr_d.version_ihl = frame_byte_i;
      end else if (offset_q == phc_pkg::ProtocolPos) begin
        hdr_d.protocol = frame_byte_i;
      end
      if (offset_q > phc_pkg::VersionPos &&
          (offset_q == tp + 7'd2 || offset_q == tp + 7'd3)) begin
        hdr_d.l4_dst_port = {hdr_q.l4_dst_port[7:0], frame_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      hdr_q <= '0;
      req_q <= '0;
    end else begin
      offset_q <= offset_d;
      hdr_q <= hdr_d;
      req_q <= req_d;
    end
  end

  assign hdr_o = hdr_q;
  assign req_o = req_q;

endmodule

FILE: src/phc_decide.sv
module phc_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  phc_pkg::req_t req_i,
  input  phc_pkg::hdr_t hdr_i,
  input  phc_pkg::cfg_t cfg_i,
  output phc_pkg::dec_t dec_o
);

  logic [15:0]                 sig;
  logic [phc_pkg::OffsetW-1:0] tp;
  logic                        base_ok;
  logic                        tcp_ok;
  logic                        udp_ok;
  phc_pkg::dec_t               dec_q, dec_d;

  assign sig = {hdr_i.mac_head[31:24] ^ hdr_i.mac_head[15:8],
                hdr_i.mac_head[23:16] ^ hdr_i.mac_head[7:0]};
  assign tp = phc_pkg::transport_offset(hdr_i.version_ihl);

  assign base_ok = req_i.pos >= phc_pkg::EthLastPos && sig == cfg_i.mac_signature &&
                   hdr_i.ether_type == phc_pkg::EtherTypeIpv4 &&
                   req_i.pos >= phc_pkg::IpLastPos &&
                   hdr_i.version_ihl[7:4] == phc_pkg::IpVersion4;
  assign tcp_ok = base_ok && hdr_i.protocol == phc_pkg::ProtoTcp &&
                  req_i.pos >= tp + 7'd3 && hdr_i.l4_dst_port == cfg_i.tcp_port;
  assign udp_ok = base_ok && hdr_i.protocol == phc_pkg::ProtoUdp;

  always_comb begin
    dec_d.valid = req_i.valid;
    dec_d.tcp_hit = req_i.valid && tcp_ok;
    dec_d.udp_hit = req_i.valid && udp_ok;
    dec_d.redirect = req_i.valid && (tcp_ok || udp_ok) && cfg_i.socket_bound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= '0;
    end else begin
      dec_q <= dec_d;
    end
  end

  assign dec_o = dec_q;

endmodule

FILE: src/phc_stats.sv
module phc_stats #(
  parameter int unsigned CountBits = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phc_pkg::dec_t        dec_i,
  output logic [CountBits-1:0] total_d_o,
  output logic [CountBits-1:0] tcp_d_o,
  output logic [CountBits-1:0] udp_d_o,
  output logic [CountBits-1:0] redirect_d_o
);

  logic [CountBits-1:0] total_q, tcp_q, udp_q, redirect_q;

  assign total_d_o = total_q + CountBits'(dec_i.valid);
  assign tcp_d_o = tcp_q + CountBits'(dec_i.tcp_hit);
  assign udp_d_o = udp_q + CountBits'(dec_i.udp_hit);
  assign redirect_d_o = redirect_q + CountBits'(dec_i.redirect);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      tcp_q <= '0;
      udp_q <= '0;
      redirect_q <= '0;
    end else begin
      total_q <= total_d_o;
      tcp_q <= tcp_d_o;
      udp_q <= udp_d_o;
      redirect_q <= redirect_d_o;
    end
  end

endmodule

FILE: src/phc_out_fifo.sv
module phc_out_fifo #(
  parameter int unsigned Width = 257,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               push_data_i,
  input  logic                           pop_i,
  output logic [Width-1:0]               data_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  assign data_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: src/phc_checker.sv
module phc_checker #(
  parameter int unsigned CountBits = 64
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 verdict_i,
  input logic [CountBits-1:0] total_i,
  input logic [CountBits-1:0] tcp_i,
  input logic [CountBits-1:0] udp_i,
  input logic [CountBits-1:0] redirect_i
);

  logic                 acc;
  logic [CountBits-1:0] total_q, tcp_q, udp_q, redirect_q;

  assign acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      tcp_q <= '0;
      udp_q <= '0;
      redirect_q <= '0;
    end else if (acc) begin
      total_q <= total_i;
      tcp_q <= tcp_i;
      udp_q <= udp_i;
      redirect_q <= redirect_i;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before it was taken");

  a_total_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> total_i == total_q + CountBits'(1))
    else $error("total count did not advance by one per item");

  a_redirect_tracks_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> redirect_i == redirect_q + CountBits'(verdict_i))
    else $error("redirect count disagrees with the verdict");

  a_redirect_needs_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && verdict_i |-> tcp_i != tcp_q || udp_i != udp_q)
    else $error("redirect without a TCP or UDP match");

  a_l4_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !(tcp_i != tcp_q && udp_i != udp_q))
    else $error("one frame counted as both TCP and UDP");

endmodule

bind packet_header_classifier phc_checker #(
  .CountBits (CounterBits)
) u_phc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .verdict_i   (result_o.verdict),
  .total_i     (result_o.total_count),
  .tcp_i       (result_o.tcp_count),
  .udp_i       (result_o.udp_count),
  .redirect_i  (result_o.redirect_count)
);

FILE: sim/tb_packet_header_classifier.sv
`timescale 1ns / 100ps

module tb_packet_header_classifier;

  localparam int CountBits = 64;
  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 7;
  localparam int DrainCycles = 8;
  localparam int LongHold = 400;
  localparam int CycleLimit = 500000;
  localparam int NumRows = 22;
  localparam int NumPhases = 5;
  localparam int PhaseBytes = 40;
  localparam int PhaseFrames = 2;

  localparam logic [15:0] SigDef = phc_pkg::MacSignatureReset;
  localparam logic [15:0] PortDef = phc_pkg::TcpDestPortReset;
  localparam logic [15:0] EtIpv4 = phc_pkg::EtherTypeIpv4;
  localparam logic [7:0] PrTcp = phc_pkg::ProtoTcp;
  localparam logic [7:0] PrUdp = phc_pkg::ProtoUdp;
  localparam logic [15:0] EtherTypeIpv6 = 16'h86DD;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  typedef enum logic [1:0] {FillRandom, FillOnes, FillZeros} fill_e;

  typedef struct packed {
    logic                 verdict;
    logic [CountBits-1:0] total;
    logic [CountBits-1:0] tcp;
    logic [CountBits-1:0] udp;
    logic [CountBits-1:0] redirect;
  } frame_verdict_t;

  typedef struct {
    int                   len;
    logic [15:0]          sig;
    logic [15:0]          etype;
    logic [7:0]           vihl;
    logic [7:0]           proto;
    logic [15:0]          dport;
    fill_e                fill;
    logic                 bound;
    logic                 typed;
    logic [CountBits-1:0] total;
  } frame_row_t;

  logic clk;
  logic rst_n;

  phc_byte_if frame_if ();
  phc_cfg_if cfg_if ();
  phc_result_if #(.CountBits(CountBits)) result_if ();

  packet_header_classifier #(
    .CounterBits(CountBits)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .frame_i (frame_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  // Rows flagged as typed carry their result in full: only the frame counter has moved.
  frame_row_t dir_rows [NumRows] = '{
    '{1, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillOnes, 1'b0, 1'b1, 64'd1},
    '{13, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd2},
    '{14, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd3},
    '{40, 16'h3606, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd4},
    '{40, SigDef, EtherTypeIpv6, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd5},
    '{33, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd6},
    '{34, SigDef, EtIpv4, 8'h65, PrUdp, PortDef, FillRandom, 1'b0, 1'b1, 64'd7},
    '{40, SigDef, EtIpv4, 8'h45, ProtoIcmp, PortDef, FillRandom, 1'b0, 1'b1, 64'd8},
    '{40, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b0, 1'b0, 64'd0},
    '{40, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillRandom, 1'b0, 1'b0, 64'd0},
    '{40, SigDef, EtIpv4, 8'h45, PrTcp, 16'd444, FillRandom, 1'b0, 1'b0, 64'd0},
    '{37, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillRandom, 1'b0, 1'b0, 64'd0},
    '{34, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{38, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{78, SigDef, EtIpv4, 8'h4F, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{77, SigDef, EtIpv4, 8'h4F, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{34, SigDef, EtIpv4, 8'h40, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{34, SigDef, EtIpv4, 8'h43, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{130, SigDef, EtIpv4, 8'h45, PrUdp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{135, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillRandom, 1'b1, 1'b0, 64'd0},
    '{40, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillOnes, 1'b1, 1'b0, 64'd0},
    '{40, SigDef, EtIpv4, 8'h45, PrTcp, PortDef, FillZeros, 1'b1, 1'b0, 64'd0}
  };

  phc_pkg::cfg_t                 cfg_shadow;
  logic [phc_pkg::OffsetW-1:0]   pos_q;
  logic [31:0]                   mac_head;
  logic [15:0]                   etype_seen;
  logic [7:0]                    vihl_seen;
  logic [7:0]                    proto_seen;
  logic [15:0]                   dport_seen;
  logic [CountBits-1:0]          frames_total;
  logic [CountBits-1:0]          frames_tcp;
  logic [CountBits-1:0]          frames_udp;
  logic [CountBits-1:0]          frames_redirected;

  frame_verdict_t verdicts_due [$];
  logic [7:0]     frame_buf [$];
  bit             quiet_tx;
  bit             hold_off_req;
  int             mismatches;
  int             cycles;

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Captures the header bytes of one item and, on a final byte, works out the verdict.
  task track_byte(input logic [7:0] b, input logic last, output logic done,
                  output frame_verdict_t v);
    int          at;
    int          tport;
    int          len;
    logic [15:0] sig;
    logic        ok;
    at = pos_q;
    done = 1'b0;
    v = '0;
    if (at >= phc_pkg::MacFirst && at <= phc_pkg::MacLast) begin
      mac_head = {mac_head[23:0], b};
    end else if (at == phc_pkg::EtherTypeHi || at == phc_pkg::EtherTypeLo) begin
      etype_seen = {etype_seen[7:0], b};
    end else if (at == phc_pkg::VersionPos) begin
      vihl_seen = b;
    end else if (at == phc_pkg::ProtocolPos) begin
      proto_seen = b;
    end
    tport = int'(phc_pkg::EthHdrLen) + 4 * int'(vihl_seen[3:0]);
    if (at > phc_pkg::VersionPos && (at == tport + 2 || at == tport + 3)) begin
      dport_seen = {dport_seen[7:0], b};
    end
    if (!last) begin
      if (pos_q != phc_pkg::OffsetMax) pos_q = pos_q + 1'b1;
    end else begin
      pos_q = '0;
      len = at + 1;
      frames_total++;
      sig = {mac_head[31:24] ^ mac_head[15:8], mac_head[23:16] ^ mac_head[7:0]};
      ok = len >= phc_pkg::EthHdrLen && sig == cfg_shadow.mac_signature
           && etype_seen == phc_pkg::EtherTypeIpv4 && len > phc_pkg::IpLastPos
           && vihl_seen[7:4] == phc_pkg::IpVersion4
           && (proto_seen == phc_pkg::ProtoTcp || proto_seen == phc_pkg::ProtoUdp);
      if (ok && proto_seen == phc_pkg::ProtoTcp) begin
        ok = len >= tport + 4 && dport_seen == cfg_shadow.tcp_port;
      end
      if (ok) begin
        if (proto_seen == phc_pkg::ProtoTcp) frames_tcp++;
        else frames_udp++;
        if (cfg_shadow.socket_bound) frames_redirected++;
      end
      v.verdict = ok && cfg_shadow.socket_bound;
      v.total = frames_total;
      v.tcp = frames_tcp;
      v.udp = frames_udp;
      v.redirect = frames_redirected;
      done = 1'b1;
    end
  endtask

  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.last_byte <= last;
    do @(posedge clk); while (!frame_if.ready);
  endtask

  task send_frame(input int len, input logic [15:0] sig, input logic [15:0] etype,
                  input logic [7:0] vihl, input logic [7:0] proto, input logic [15:0] dport,
                  input fill_e fill, input logic typed, input logic [CountBits-1:0] total);
    int             span;
    int             tport;
    logic           done;
    frame_verdict_t v;
    frame_verdict_t typed_v;
    span = (len > 80) ? len : 80;
    typed_v = '{verdict: 1'b0, total: total, tcp: '0, udp: '0, redirect: '0};
    frame_buf.delete();
    for (int i = 0; i < span; i++) begin
      case (fill)
        FillOnes: frame_buf.push_back(8'hFF);
        FillZeros: frame_buf.push_back(8'h00);
        default: frame_buf.push_back(8'($urandom));
      endcase
    end
    if (fill == FillRandom) begin
      tport = int'(phc_pkg::EthHdrLen) + 4 * int'(vihl[3:0]);
      frame_buf[phc_pkg::MacFirst + 2] = frame_buf[phc_pkg::MacFirst] ^ sig[15:8];
      frame_buf[phc_pkg::MacLast] = frame_buf[phc_pkg::MacFirst + 1] ^ sig[7:0];
      frame_buf[phc_pkg::EtherTypeHi] = etype[15:8];
      frame_buf[phc_pkg::EtherTypeLo] = etype[7:0];
      frame_buf[phc_pkg::VersionPos] = vihl;
      frame_buf[phc_pkg::ProtocolPos] = proto;
      frame_buf[tport + 2] = dport[15:8];
      frame_buf[tport + 3] = dport[7:0];
    end
    for (int i = 0; i < len; i++) begin
      send_byte(frame_buf[i], i == len - 1);
      track_byte(frame_buf[i], i == len - 1, done, v);
      if (done) verdicts_due.push_back(typed ? typed_v : v);
    end
  endtask

  task write_reg(input logic [phc_pkg::CfgIdxW-1:0] idx,
                 input logic [phc_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      phc_pkg::CfgMacSignature: cfg_shadow.mac_signature = val;
      phc_pkg::CfgTcpDestPort: cfg_shadow.tcp_port = val;
      phc_pkg::CfgSocketBound: cfg_shadow.socket_bound = val[0];
      default: ;
    endcase
  endtask

  task program_regs(input logic [15:0] sig, input logic [15:0] port, input logic bound);
    write_reg(phc_pkg::CfgMacSignature, sig);
    write_reg(phc_pkg::CfgTcpDestPort, port);
    write_reg(phc_pkg::CfgSocketBound, {15'd0, bound});
    cfg_if.valid <= 1'b0;
  endtask

  task settle();
    frame_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    frame_verdict_t due;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result item: verdict %0d, total_count %0d",
               result_if.verdict, result_if.total_count);
        mismatches++;
      end else begin
        due = verdicts_due.pop_front();
        if (result_if.verdict !== due.verdict) begin
          $error("verdict: expected %0d, got %0d", due.verdict, result_if.verdict);
          mismatches++;
        end
        if (result_if.total_count !== due.total) begin
          $error("total_count: expected %0d, got %0d", due.total, result_if.total_count);
          mismatches++;
        end
        if (result_if.tcp_count !== due.tcp) begin
          $error("tcp_count: expected %0d, got %0d", due.tcp, result_if.tcp_count);
          mismatches++;
        end
        if (result_if.udp_count !== due.udp) begin
          $error("udp_count: expected %0d, got %0d", due.udp, result_if.udp_count);
          mismatches++;
        end
        if (result_if.redirect_count !== due.redirect) begin
          $error("redirect_count: expected %0d, got %0d", due.redirect,
                 result_if.redirect_count);
          mismatches++;
        end
      end
    end
  end

  // The receiver stalls for a random while before most items, sometimes not at all for a stretch, and once
  // for a long time so that results back up into the block.
  initial begin
    int stall;
    int calm_left;
    calm_left = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LongHold;
      end else if (calm_left != 0) begin
        calm_left--;
        stall = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        calm_left = $urandom_range(8, 30);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
      end
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  initial begin
    int          kind;
    int          ihl;
    int          tport;
    int          len;
    int          phase_bytes;
    int          phase_frames;
    logic [15:0] sig;
    logic [15:0] etype;
    logic [15:0] dport;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    clk = 1'b0;
    rst_n = 1'b0;
    frame_if.valid <= 1'b0;
    frame_if.frame_byte <= '0;
    frame_if.last_byte <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    result_if.ready <= 1'b0;
    cfg_shadow = '{mac_signature: phc_pkg::MacSignatureReset,
                   tcp_port: phc_pkg::TcpDestPortReset, socket_bound: 1'b0};
    pos_q = '0;
    mac_head = '0;
    etype_seen = '0;
    vihl_seen = '0;
    proto_seen = '0;
    dport_seen = '0;
    frames_total = '0;
    frames_tcp = '0;
    frames_udp = '0;
    frames_redirected = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].bound != cfg_shadow.socket_bound) begin
        settle();
        program_regs(cfg_shadow.mac_signature, cfg_shadow.tcp_port, dir_rows[r].bound);
      end
      send_frame(dir_rows[r].len, dir_rows[r].sig, dir_rows[r].etype, dir_rows[r].vihl,
                 dir_rows[r].proto, dir_rows[r].dport, dir_rows[r].fill, dir_rows[r].typed,
                 dir_rows[r].total);
    end
    settle();

    // Short frames offered back to back while the receiver holds off.
    quiet_tx = 1'b1;
    hold_off_req = 1'b1;
    repeat (16) begin
      send_frame($urandom_range(1, 4), 16'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), 16'($urandom), FillRandom, 1'b0, '0);
    end
    quiet_tx = 1'b0;
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: program_regs(16'h0000, 16'h0000, 1'b1);
        1: program_regs(16'hFFFF, 16'hFFFF, 1'b1);
        2: program_regs(16'($urandom), 16'($urandom), 1'b0);
        3: program_regs(16'($urandom), 16'($urandom), 1'b1);
        default: program_regs(phc_pkg::MacSignatureReset, phc_pkg::TcpDestPortReset, 1'b1);
      endcase
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < PhaseBytes || phase_frames < PhaseFrames) begin
        kind = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 2) != 0) ? 5 : $urandom_range(0, 15);
        tport = int'(phc_pkg::EthHdrLen) + 4 * ihl;
        sig = ($urandom_range(0, 9) != 0) ? cfg_shadow.mac_signature : 16'($urandom);
        etype = ($urandom_range(0, 9) != 0) ? phc_pkg::EtherTypeIpv4 : 16'($urandom);
        vihl = {($urandom_range(0, 9) != 0) ? phc_pkg::IpVersion4 : 4'($urandom), 4'(ihl)};
        case ($urandom_range(0, 9))
          0: proto = 8'($urandom);
          1, 2, 3, 4: proto = phc_pkg::ProtoUdp;
          default: proto = phc_pkg::ProtoTcp;
        endcase
        dport = ($urandom_range(0, 4) != 0) ? cfg_shadow.tcp_port : 16'($urandom);
        if (kind < 20) begin
          len = $urandom_range(1, 40);
        end else if (kind < 30) begin
          len = $urandom_range(int'(phc_pkg::EthHdrLen), tport + 3);
        end else if (kind < 35) begin
          len = $urandom_range(128, 220);
        end else begin
          len = ((tport + 4 > phc_pkg::IpLastPos + 1) ? tport + 4 : phc_pkg::IpLastPos + 1)
                + $urandom_range(0, 12);
        end
        quiet_tx = ($urandom_range(0, 4) == 0);
        send_frame(len, sig, etype, vihl, proto, dport, FillRandom, 1'b0, '0);
        phase_bytes += len;
        phase_frames++;
      end
      quiet_tx = 1'b0;
      settle();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
